// ----- design/srcache_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the source route cache.
// No dependencies; used by srcache_cell and source_route_cache.
package srcache_pkg;

    localparam int MAC_W   = 48;
    localparam int SIZE_W  = 5;
    localparam int WORD_W  = 64;
    localparam int TOP_W   = 16;
    localparam int STAMP_W = 32;

    localparam logic [SIZE_W-1:0] MAX_ROUTE_BYTES = 5'd18;

    // request types
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_TICKS   = 1'd1;
    localparam int CFG_DATA_W = 32;
    localparam logic [STAMP_W-1:0] AGE_TICKS_RESET = 32'd120000;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [MAC_W-1:0]  mac_addr;
        logic [SIZE_W-1:0] route_size;
        logic [WORD_W-1:0] route_bytes_low;
        logic [WORD_W-1:0] route_bytes_mid;
        logic [TOP_W-1:0]  route_bytes_top;
    } srcache_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIZE_W-1:0] found_size;
        logic [WORD_W-1:0] found_low;
        logic [WORD_W-1:0] found_mid;
        logic [TOP_W-1:0]  found_top;
    } srcache_rsp_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic               active;
        logic [MAC_W-1:0]   key;
        logic               found;
        logic               free_found;
        logic [SIZE_W-1:0]  size;
        logic [WORD_W-1:0]  low;
        logic [WORD_W-1:0]  mid;
        logic [TOP_W-1:0]   top;
        logic [STAMP_W-1:0] stamp;
    } srcache_tok_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               clear;
        logic [MAC_W-1:0]   key;
        logic [SIZE_W-1:0]  size;
        logic [WORD_W-1:0]  low;
        logic [WORD_W-1:0]  mid;
        logic [TOP_W-1:0]   top;
        logic [STAMP_W-1:0] stamp;
    } srcache_wr_t;

    // bytes below count n inside the 8-byte word starting at byte base
    function automatic logic [WORD_W-1:0] byte_mask(input logic [SIZE_W-1:0] n,
                                                    input int base);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W / 8; b++)
        begin
            m[8*b +: 8] = {8{n > SIZE_W'(base + b)}};
        end
        return m;
    endfunction

endpackage

// ----- design/srcache_cell.sv -----
`timescale 1ns / 1ps
// One table slot of the route cache chain: holds an entry, checks the passing
// search token and takes writes addressed to its slot. Uses srcache_pkg.
module srcache_cell
    import srcache_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  srcache_tok_t       tok_in,
    input  logic [IDX_W-1:0]   match_in,
    input  logic [IDX_W-1:0]   free_in,
    output srcache_tok_t       tok_out,
    output logic [IDX_W-1:0]   match_out,
    output logic [IDX_W-1:0]   free_out,
    input  srcache_wr_t        wr,
    input  logic [IDX_W-1:0]   wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               valid_reg;
    logic [MAC_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [WORD_W-1:0]  low_reg;
    logic [WORD_W-1:0]  mid_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [STAMP_W-1:0] stamp_reg;

    srcache_tok_t       tok_reg, tok_next;
    logic [IDX_W-1:0]   match_reg, match_next;
    logic [IDX_W-1:0]   free_reg, free_next;
    logic               wr_hit;
    logic               hit;

    assign wr_hit = wr.en && (wr_idx == MY_IDX);
    assign hit    = valid_reg && (key_reg == tok_in.key);

    always_comb
    begin
        tok_next   = tok_in;
        match_next = match_in;
        free_next  = free_in;
        if (hit && !tok_in.found)
        begin
            tok_next.found = 1'b1;
            tok_next.size  = size_reg;
            tok_next.low   = low_reg;
            tok_next.mid   = mid_reg;
            tok_next.top   = top_reg;
            tok_next.stamp = stamp_reg;
            match_next     = MY_IDX;
        end
        if (!valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            free_next           = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
            match_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg <= !wr.clear;
            end
            tok_reg   <= tok_next;
            match_reg <= match_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit && !wr.clear)
        begin
            key_reg   <= wr.key;
            size_reg  <= wr.size;
            low_reg   <= wr.low;
            mid_reg   <= wr.mid;
            top_reg   <= wr.top;
            stamp_reg <= wr.stamp;
        end
    end

    assign tok_out   = tok_reg;
    assign match_out = match_reg;
    assign free_out  = free_reg;

endmodule

// ----- design/source_route_cache.sv -----
`timescale 1ns / 1ps
// Source route cache top level: request control, cell chain, result register.
// Uses srcache_pkg and srcache_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one request item: lookup,
//   insert, delete or clock tick. rsp channel (rsp_valid/rsp_ready/rsp) gives
//   exactly one result item per request, in order.
//   cfg channel writes insert_mode (index 0) and age_ticks (index 1); it is
//   always ready and should be used only while no request is in flight.
// Sequencing:
//   A request sends a search token down a chain of ENTRIES cells, one cell
//   per cycle; the tail result is then resolved and any table write lands
//   in the cycle after. A new item is taken only once the previous one has
//   been resolved, so items never overlap in the chain.
// Reset:
//   All slots become free, the tick clock returns to zero, insert_mode to 0
//   and age_ticks to 120000. No clearing pass is needed.
// Stall:
//   The result sits in an output register; the next item is accepted while
//   it waits, but its own result is held in the chain tail until the
//   register frees up.
module source_route_cache
    import srcache_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  srcache_req_t          req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output srcache_rsp_t          rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         type_reg;
    logic [MAC_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [WORD_W-1:0]  low_reg;
    logic [WORD_W-1:0]  mid_reg;
    logic [TOP_W-1:0]   top_reg;
    logic               inject_reg;

    logic               mode_reg;
    logic [STAMP_W-1:0] age_reg;
    logic [STAMP_W-1:0] now_reg;

    srcache_tok_t       tail_reg;
    logic [IDX_W-1:0]   tail_match_reg;
    logic [IDX_W-1:0]   tail_free_reg;

    srcache_wr_t        wr_reg, wr_next;
    logic [IDX_W-1:0]   wr_idx_reg;
    srcache_rsp_t       rsp_reg, rsp_next;
    logic               rsp_valid_reg;

    srcache_tok_t       head_tok;
    srcache_tok_t       tok_chain   [0:ENTRIES];
    logic [IDX_W-1:0]   match_chain [0:ENTRIES];
    logic [IDX_W-1:0]   free_chain  [0:ENTRIES];

    logic               req_fire;
    logic               resolve_fire;
    logic [SIZE_W-1:0]  size_sat;
    logic [WORD_W-1:0]  top_mask;
    logic [STAMP_W-1:0] age_diff;
    logic               too_young;

    assign req_ready    = (state_reg == S_IDLE);
    assign req_fire     = req_valid && req_ready;
    assign resolve_fire = (state_reg == S_RESOLVE) && (!rsp_valid_reg || rsp_ready);
    assign cfg_ready    = 1'b1;

    assign size_sat  = (req.route_size > MAX_ROUTE_BYTES) ? MAX_ROUTE_BYTES
                                                          : req.route_size;
    assign top_mask  = byte_mask(size_sat, 16);
    assign age_diff  = now_reg - tail_reg.stamp;
    assign too_young = mode_reg && (age_diff < age_reg);

    // chain head: fresh token, nothing found yet
    always_comb
    begin
        head_tok        = '0;
        head_tok.active = inject_reg;
        head_tok.key    = key_reg;
    end

    assign tok_chain[0]   = head_tok;
    assign match_chain[0] = '0;
    assign free_chain[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        srcache_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok_chain[i]),
            .match_in  (match_chain[i]),
            .free_in   (free_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .match_out (match_chain[i+1]),
            .free_out  (free_chain[i+1]),
            .wr        (wr_reg),
            .wr_idx    (wr_idx_reg)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_chain[ENTRIES].active)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (resolve_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table write and result for the item at the chain tail
    always_comb
    begin
        wr_next       = '0;
        wr_next.clear = (type_reg == REQ_DELETE);
        wr_next.key   = key_reg;
        wr_next.size  = size_reg;
        wr_next.low   = low_reg;
        wr_next.mid   = mid_reg;
        wr_next.top   = top_reg;
        wr_next.stamp = now_reg;
        rsp_next      = '0;
        case (type_reg)
            REQ_LOOKUP:
            begin
                if (tail_reg.found)
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.found_size = tail_reg.size;
                    rsp_next.found_low  = tail_reg.low;
                    rsp_next.found_mid  = tail_reg.mid;
                    rsp_next.found_top  = tail_reg.top;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            REQ_INSERT:
            begin
                if (tail_reg.found)
                begin
                    if (too_young)
                    begin
                        rsp_next.status = ST_IGNORED;
                    end
                    else
                    begin
                        rsp_next.status = ST_OK;
                        wr_next.en      = 1'b1;
                    end
                end
                else if (tail_reg.free_found)
                begin
                    rsp_next.status = ST_OK;
                    wr_next.en      = 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            REQ_DELETE:
            begin
                if (tail_reg.found)
                begin
                    rsp_next.status = ST_OK;
                    wr_next.en      = 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inject_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            age_reg       <= AGE_TICKS_RESET;
            now_reg       <= '0;
            wr_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= req_fire;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INSERT_MODE: mode_reg <= cfg_data[0];
                    CFG_AGE_TICKS:   age_reg  <= cfg_data[STAMP_W-1:0];
                    default:         ;
                endcase
            end

            if (resolve_fire)
            begin
                rsp_valid_reg <= 1'b1;
                wr_reg        <= wr_next;
                if (type_reg == REQ_TICK)
                begin
                    now_reg <= now_reg + STAMP_W'(1);
                end
            end
            else
            begin
                wr_reg.en <= 1'b0;
                if (rsp_ready)
                begin
                    rsp_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg <= req.req_type;
            key_reg  <= req.mac_addr;
            size_reg <= size_sat;
            low_reg  <= req.route_bytes_low & byte_mask(size_sat, 0);
            mid_reg  <= req.route_bytes_mid & byte_mask(size_sat, 8);
            top_reg  <= req.route_bytes_top & top_mask[TOP_W-1:0];
        end

        if ((state_reg == S_SCAN) && tok_chain[ENTRIES].active)
        begin
            tail_reg       <= tok_chain[ENTRIES];
            tail_match_reg <= match_chain[ENTRIES];
            tail_free_reg  <= free_chain[ENTRIES];
        end

        if (resolve_fire)
        begin
            wr_idx_reg <= tail_reg.found ? tail_match_reg : tail_free_reg;
            rsp_reg    <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for source_route_cache: directed rows, then random request mixes with config phases.
// Depends on srcache_pkg and the source_route_cache RTL only.
module tb;
    import srcache_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int ROUTE_W      = 2 * WORD_W + TOP_W;
    localparam int POOL_SIZE    = 80;
    localparam int RSP_LATENCY  = ENTRIES + 4;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 4000;

    localparam logic [MAC_W-1:0] KEY_ZERO = '0;
    localparam logic [MAC_W-1:0] KEY_ONES = '1;
    localparam logic [MAC_W-1:0] KEY_B    = 48'h1234_5678_9ABC;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        srcache_req_t          item;
        bit                    typed;
        srcache_rsp_t          want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    srcache_req_t          req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    srcache_rsp_t          rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_INSERT_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // route table model
    logic               tbl_valid [ENTRIES] = '{default: 1'b0};
    logic [MAC_W-1:0]   tbl_key   [ENTRIES];
    logic [SIZE_W-1:0]  tbl_size  [ENTRIES];
    logic [ROUTE_W-1:0] tbl_route [ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [ENTRIES];
    logic [STAMP_W-1:0] tick_now = '0;
    logic               mode_aging = 1'b0;
    logic [STAMP_W-1:0] min_age = AGE_TICKS_RESET;

    srcache_rsp_t       rsp_due [$];
    stim_row_t          directed_rows [$];
    logic [MAC_W-1:0]   key_pool [POOL_SIZE];

    bit                 row_typed = 1'b0;
    srcache_rsp_t       row_want = '0;
    int                 sender_idle_pct = 0;
    int                 rsp_stall_pct = 0;
    bit                 hold_start = 1'b0;
    bit                 hold_rsp = 1'b0;
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;

    source_route_cache #(.ENTRIES(ENTRIES)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one table request against the model; updates model state
    function automatic srcache_rsp_t cache_access(input srcache_req_t r);
        srcache_rsp_t       o;
        int                 hit;
        int                 slot;
        int                 n_bytes;
        logic [SIZE_W-1:0]  n;
        logic [ROUTE_W-1:0] route;
        logic [STAMP_W-1:0] age;
        o = '0;
        o.status = ST_OK;
        n = (r.route_size > MAX_ROUTE_BYTES) ? MAX_ROUTE_BYTES : r.route_size;
        n_bytes = int'(n);
        route = {r.route_bytes_top, r.route_bytes_mid, r.route_bytes_low};
        for (int b = 0; b < ROUTE_W / 8; b++)
        begin
            if (b >= n_bytes)
                route[8*b +: 8] = '0;
        end
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == r.mac_addr)
                hit = i;
        end
        case (r.req_type)
            REQ_LOOKUP:
            begin
                if (hit < 0)
                    o.status = ST_NOT_FOUND;
                else
                begin
                    o.found_size = tbl_size[hit];
                    {o.found_top, o.found_mid, o.found_low} = tbl_route[hit];
                end
            end
            REQ_INSERT:
            begin
                slot = hit;
                if (hit < 0)
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!tbl_valid[i])
                            slot = i;
                    end
                end
                age = (hit >= 0) ? tick_now - tbl_stamp[hit] : '0;
                if (slot < 0)
                    o.status = ST_FULL;
                else if (hit >= 0 && mode_aging && age < min_age)
                    o.status = ST_IGNORED;
                else
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = r.mac_addr;
                    tbl_size[slot]  = n;
                    tbl_route[slot] = route;
                    tbl_stamp[slot] = tick_now;
                end
            end
            REQ_DELETE:
            begin
                if (hit < 0)
                    o.status = ST_NOT_FOUND;
                else
                    tbl_valid[hit] = 1'b0;
            end
            REQ_TICK:
                tick_now = tick_now + 32'd1;
            default:
                ;
        endcase
        return o;
    endfunction

    function automatic srcache_req_t req_of(input logic [1:0] kind,
                                            input logic [MAC_W-1:0] mac,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] mid,
                                            input logic [TOP_W-1:0] hi);
        srcache_req_t r;
        r.req_type        = kind;
        r.mac_addr        = mac;
        r.route_size      = size;
        r.route_bytes_low = lo;
        r.route_bytes_mid = mid;
        r.route_bytes_top = hi;
        return r;
    endfunction

    function automatic srcache_rsp_t rsp_of(input logic [1:0] st,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] mid,
                                            input logic [TOP_W-1:0] hi);
        srcache_rsp_t o;
        o.status     = st;
        o.found_size = size;
        o.found_low  = lo;
        o.found_mid  = mid;
        o.found_top  = hi;
        return o;
    endfunction

    function automatic srcache_req_t rand_req(input int tick_pct, input int insert_pct);
        srcache_req_t r;
        int           roll;
        logic [63:0]  wide;
        logic [31:0]  pick;
        roll = int'($urandom_range(99, 0));
        if (roll < tick_pct)
            r.req_type = REQ_TICK;
        else if (roll < tick_pct + insert_pct)
            r.req_type = REQ_INSERT;
        else if ($urandom_range(9, 0) < 7)
            r.req_type = REQ_LOOKUP;
        else
            r.req_type = REQ_DELETE;
        wide = {$urandom, $urandom};
        if ($urandom_range(9, 0) == 0)
            r.mac_addr = wide[MAC_W-1:0];
        else
            r.mac_addr = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
        // mostly legal sizes, the rest oversized
        pick = ($urandom_range(1, 0) == 0) ? $urandom_range(18, 0) : $urandom_range(31, 0);
        r.route_size      = pick[SIZE_W-1:0];
        r.route_bytes_low = {$urandom, $urandom};
        r.route_bytes_mid = {$urandom, $urandom};
        pick              = $urandom;
        r.route_bytes_top = pick[TOP_W-1:0];
        return r;
    endfunction

    // expectation store and result checking
    always @(posedge clk)
    begin : scoreboard
        srcache_rsp_t predicted;
        srcache_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predicted = cache_access(req);
                rsp_due.push_back(row_typed ? row_want : predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_INSERT_MODE)
                    mode_aging = cfg_data[0];
                else if (cfg_index == CFG_AGE_TICKS)
                    min_age = cfg_data;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("result item with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.found_size !== want.found_size)
                    begin
                        $error("found_size: expected %0d, got %0d",
                               want.found_size, rsp.found_size);
                        mismatch_count++;
                    end
                    if (rsp.found_low !== want.found_low)
                    begin
                        $error("found_low: expected %h, got %h", want.found_low, rsp.found_low);
                        mismatch_count++;
                    end
                    if (rsp.found_mid !== want.found_mid)
                    begin
                        $error("found_mid: expected %h, got %h", want.found_mid, rsp.found_mid);
                        mismatch_count++;
                    end
                    if (rsp.found_top !== want.found_top)
                    begin
                        $error("found_top: expected %h, got %h", want.found_top, rsp.found_top);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off
    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
    end

    initial
    begin
        wait (hold_start);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // entered and left at a falling edge
    task automatic drive_req(input srcache_req_t item, input bit typed, input srcache_rsp_t want);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed = typed;
        row_want  = want;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int count, input int tick_pct, input int insert_pct);
        for (int k = 0; k < count; k++)
            drive_req(rand_req(tick_pct, insert_pct), 1'b0, '0);
    endtask

    task automatic set_pressure(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        rsp_stall_pct   = stall_pct;
    endtask

    // insert every pool key in turn so the table overflows
    task automatic fill_table();
        srcache_req_t r;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            r = rand_req(0, 100);
            r.mac_addr = key_pool[k];
            drive_req(r, 1'b0, '0);
            if (k % 4 == 3)
                drive_req(rand_req(0, 0), 1'b0, '0);
        end
    endtask

    task automatic add_req(input srcache_req_t item, input bit typed, input srcache_rsp_t want);
        stim_row_t row;
        row = '{default: '0};
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        directed_rows.push_back(row);
    endtask

    initial
    begin : main
        logic [63:0]  wide;
        srcache_rsp_t none;
        none = '0;
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        key_pool[2] = KEY_B;
        for (int k = 3; k < POOL_SIZE; k++)
        begin
            wide = {$urandom, $urandom};
            key_pool[k] = wide[MAC_W-1:0];
        end

        // empty table, ticks, size extremes
        add_req(req_of(REQ_LOOKUP, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_NOT_FOUND, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_DELETE, KEY_ONES, 5'd31, '1, '1, '1), 1'b1,
                rsp_of(ST_NOT_FOUND, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_TICK, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_INSERT, KEY_ZERO, 5'd0, '1, '1, '1), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_LOOKUP, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_INSERT, KEY_ONES, 5'd31, '1, '1, '1), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_LOOKUP, KEY_ONES, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_OK, MAX_ROUTE_BYTES, '1, '1, '1));
        // partial sizes, overwrite with mode 0
        add_req(req_of(REQ_INSERT, KEY_B, 5'd5, 64'h0123_4567_89AB_CDEF,
                       64'hFEDC_BA98_7654_3210, 16'hA5C3), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_LOOKUP, KEY_B, 5'd0, '0, '0, '0), 1'b0, none);
        add_req(req_of(REQ_INSERT, KEY_B, 5'd17, 64'hFFFF_0000_FFFF_0000,
                       64'h1357_9BDF_2468_ACE0, 16'hFFFF), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_LOOKUP, KEY_B, 5'd0, '0, '0, '0), 1'b0, none);
        add_req(req_of(REQ_INSERT, KEY_B, 5'd8, '1, '1, '1), 1'b0, none);
        add_req(req_of(REQ_LOOKUP, KEY_B, 5'd0, '0, '0, '0), 1'b0, none);
        add_req(req_of(REQ_INSERT, KEY_B, 5'd16, '1, '1, '1), 1'b0, none);
        add_req(req_of(REQ_LOOKUP, KEY_B, 5'd0, '0, '0, '0), 1'b0, none);
        add_req(req_of(REQ_DELETE, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_LOOKUP, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_NOT_FOUND, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_DELETE, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_NOT_FOUND, 5'd0, '0, '0, '0));
        // aging: KEY_B stamped at tick 1, age limit 2
        add_cfg(CFG_INSERT_MODE, 32'd1);
        add_cfg(CFG_AGE_TICKS, 32'd2);
        add_req(req_of(REQ_INSERT, KEY_B, 5'd3, '1, '1, '1), 1'b1,
                rsp_of(ST_IGNORED, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_TICK, KEY_ONES, 5'd31, '1, '1, '1), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_INSERT, KEY_B, 5'd3, '1, '1, '1), 1'b1,
                rsp_of(ST_IGNORED, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_TICK, KEY_ZERO, 5'd0, '0, '0, '0), 1'b1,
                rsp_of(ST_OK, 5'd0, '0, '0, '0));
        add_req(req_of(REQ_INSERT, KEY_B, 5'd18, 64'h0F1E_2D3C_4B5A_6978,
                       64'h8796_A5B4_C3D2_E1F0, 16'h7E81), 1'b0, none);
        add_req(req_of(REQ_LOOKUP, KEY_B, 5'd0, '0, '0, '0), 1'b0, none);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            else
                drive_req(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        write_reg(CFG_INSERT_MODE, 32'd0);
        write_reg(CFG_AGE_TICKS, AGE_TICKS_RESET);
        set_pressure(0, 0);
        run_mix(180, 10, 40);

        set_pressure(51, 0);
        fill_table();
        run_mix(20, 5, 60);

        // aging with zero age never blocks an update
        write_reg(CFG_INSERT_MODE, 32'd1);
        write_reg(CFG_AGE_TICKS, 32'd0);
        set_pressure(0, 51);
        run_mix(120, 15, 40);

        // maximum age blocks nearly every update
        write_reg(CFG_AGE_TICKS, 32'hFFFF_FFFF);
        set_pressure(19, 19);
        run_mix(100, 15, 45);

        // short age, tick heavy; long receiver hold-off, then a full drain
        write_reg(CFG_AGE_TICKS, 32'd5);
        set_pressure(0, 0);
        hold_start = 1'b1;
        run_mix(70, 35, 35);
        wait_for_results();
        run_mix(80, 35, 35);

        // back to plain overwrite, delete heavy
        write_reg(CFG_INSERT_MODE, 32'd0);
        write_reg(CFG_AGE_TICKS, 32'd3);
        set_pressure(51, 0);
        run_mix(100, 5, 15);

        wait_for_results();
        repeat (2 * RSP_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
